// File: src/pbu_pkg.sv
`timescale 1ns / 1ps

package pbu_pkg;

  // Default frame and output geometry
  localparam int unsigned SRC_WIDTH_DEF  = 128;
  localparam int unsigned SRC_HEIGHT_DEF = 64;
  localparam int unsigned DST_WIDTH_DEF  = 480;
  localparam int unsigned DST_HEIGHT_DEF = 320;

  // Field widths of the channel words
  localparam int unsigned CMD_W     = 1;
  localparam int unsigned ADDR_W    = 10;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned ROW_W     = 9;
  localparam int unsigned PIXELS_W  = 64;
  localparam int unsigned WIDX_W    = 5;

  localparam int unsigned MAX_WORDS       = 30;
  localparam int unsigned PIX_PER_WORD    = 16;
  localparam logic [2:0]  LIT_BITS        = 3'b111;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_RENDER = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BASE,
    ST_ISSUE,
    ST_FLUSH,
    ST_PUSH
  } state_e;

endpackage

// File: src/pbu_in_if.sv
`timescale 1ns / 1ps

interface pbu_in_if;
  logic                        valid;
  logic                        ready;
  logic [pbu_pkg::CMD_W-1:0]   cmd;
  logic [pbu_pkg::ADDR_W-1:0]  address;
  logic [pbu_pkg::DATA_W-1:0]  data;
  logic [pbu_pkg::ROW_W-1:0]   row;

  modport source (output valid, cmd, address, data, row, input ready);
  modport sink   (input valid, cmd, address, data, row, output ready);
endinterface

// File: src/pbu_out_if.sv
`timescale 1ns / 1ps

interface pbu_out_if;
  logic                          valid;
  logic                          ready;
  logic [pbu_pkg::PIXELS_W-1:0]  pixels;
  logic [pbu_pkg::WIDX_W-1:0]    word_index;
  logic                          last;

  modport source (output valid, pixels, word_index, last, input ready);
  modport sink   (input valid, pixels, word_index, last, output ready);
endinterface

// File: src/page_buffer_line_upscaler.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake        Payload
// in_i     in   valid / ready    cmd, address[9:0], data[7:0], row[8:0]
// out_o    out  valid / ready    pixels[63:0], word_index[4:0], last
//
// A write word goes straight into the frame RAM. A render word computes the
// source row base (ST_BASE), then for each output word (30 by default)
// issues 16 pixel reads on the single RAM read port (ST_ISSUE), drains the
// last read (ST_FLUSH) and hands the word into the output register (ST_PUSH),
// waiting while out_o stalls. After reset the frame RAM is cleared one byte
// per cycle (FrameBytes, 1024 by default); in_i.ready stays low until done.

module page_buffer_line_upscaler #(
  parameter int unsigned SRC_WIDTH  = pbu_pkg::SRC_WIDTH_DEF,
  parameter int unsigned SRC_HEIGHT = pbu_pkg::SRC_HEIGHT_DEF,
  parameter int unsigned DST_WIDTH  = pbu_pkg::DST_WIDTH_DEF,
  parameter int unsigned DST_HEIGHT = pbu_pkg::DST_HEIGHT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbu_in_if.sink    in_i,
  pbu_out_if.source out_o
);

  localparam int unsigned FrameBytes = SRC_WIDTH * ((SRC_HEIGHT + 7) / 8);
  localparam int unsigned AW         = $clog2(FrameBytes);
  localparam int unsigned RowBytes   = (DST_WIDTH + 1) / 2;
  localparam int unsigned RowWords   = (RowBytes + 7) / 8;
  localparam int unsigned NumWords   = (RowWords > pbu_pkg::MAX_WORDS) ?
                                       pbu_pkg::MAX_WORDS : RowWords;
  localparam int unsigned XW         = $clog2(pbu_pkg::PIX_PER_WORD * NumWords + 1);
  localparam int unsigned CW         = $clog2(SRC_WIDTH + 1);
  localparam int unsigned AccW       = $clog2(2 * DST_WIDTH);
  localparam int unsigned ColInt     = SRC_WIDTH / DST_WIDTH;
  localparam int unsigned ColFrac    = SRC_WIDTH % DST_WIDTH;
  localparam int unsigned Scale      = (DST_HEIGHT / SRC_HEIGHT == 0) ? 1 :
                                       DST_HEIGHT / SRC_HEIGHT;
  localparam int unsigned DivShift   = 17;
  localparam int unsigned DivMul     = ((1 << DivShift) + Scale - 1) / Scale;
  localparam int unsigned ProdW      = pbu_pkg::ROW_W + DivShift + 1;
  localparam int unsigned QW         = ProdW - DivShift;

  function automatic logic [pbu_pkg::PIXELS_W-1:0] pack_word(
    input logic [pbu_pkg::PIX_PER_WORD-1:0] lit
  );
    logic [pbu_pkg::PIXELS_W-1:0] w;
    w = '0;
    for (int b = 0; b < 8; b++) begin
      w[b*8+3 +: 3] = lit[2*b]     ? pbu_pkg::LIT_BITS : 3'b000;
      w[b*8   +: 3] = lit[2*b + 1] ? pbu_pkg::LIT_BITS : 3'b000;
    end
    return w;
  endfunction

  pbu_pkg::state_e state_q, state_d;

  logic [AW-1:0]        clr_q, clr_d;
  logic [QW-1:0]        quot_q, quot_d;
  logic [AW-1:0]        base_q, base_d;
  logic [2:0]           bit_q, bit_d;
  logic [XW-1:0]        x_q, x_d;
  logic [CW-1:0]        col_q, col_d;
  logic [AccW-1:0]      acc_q, acc_d;
  logic [3:0]           pos_q, pos_d;
  logic [4:0]           word_q, word_d;
  logic                 p1_vld_q, p1_vld_d;
  logic                 p1_ok_q, p1_ok_d;
  logic [3:0]           p1_pos_q, p1_pos_d;
  logic [pbu_pkg::PIX_PER_WORD-1:0] lit_q;

  logic                             out_vld_q, out_vld_d;
  logic [pbu_pkg::PIXELS_W-1:0]     pixels_q, pixels_d;
  logic [pbu_pkg::WIDX_W-1:0]       widx_q, widx_d;
  logic                             last_q, last_d;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;

  logic [ProdW-1:0] prod;
  logic [31:0]      src_row;
  logic [31:0]      base_full;
  logic [31:0]      wr_addr_ext;
  logic             x_ok;
  logic [CW-1:0]    col_sat;
  logic [AccW-1:0]  acc_sum;
  logic             acc_wrap;

  assign prod        = ProdW'(in_i.row) * ProdW'(DivMul);
  assign src_row     = (32'(quot_q) >= SRC_HEIGHT) ? SRC_HEIGHT - 1 : 32'(quot_q);
  assign base_full   = (src_row >> 3) * SRC_WIDTH;
  assign wr_addr_ext = 32'(in_i.address);
  assign x_ok        = 32'(x_q) < DST_WIDTH;
  assign col_sat     = (32'(col_q) >= SRC_WIDTH) ? CW'(SRC_WIDTH - 1) : col_q;
  assign acc_sum     = acc_q + AccW'(ColFrac);
  assign acc_wrap    = 32'(acc_sum) >= DST_WIDTH;
  assign ram_raddr   = base_q + AW'(col_sat);

  assign in_i.ready       = (state_q == pbu_pkg::ST_IDLE);
  assign out_o.valid      = out_vld_q;
  assign out_o.pixels     = pixels_q;
  assign out_o.word_index = widx_q;
  assign out_o.last       = last_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    quot_d    = quot_q;
    base_d    = base_q;
    bit_d     = bit_q;
    x_d       = x_q;
    col_d     = col_q;
    acc_d     = acc_q;
    pos_d     = pos_q;
    word_d    = word_q;
    p1_vld_d  = 1'b0;
    p1_ok_d   = p1_ok_q;
    p1_pos_d  = p1_pos_q;
    out_vld_d = out_vld_q && !out_o.ready;
    pixels_d  = pixels_q;
    widx_d    = widx_q;
    last_d    = last_q;
    ram_we    = 1'b0;
    ram_waddr = wr_addr_ext[AW-1:0];
    ram_wdata = in_i.data;

    unique case (state_q)
      pbu_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (32'(clr_q) == FrameBytes - 1) begin
          state_d = pbu_pkg::ST_IDLE;
        end
      end
      pbu_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.cmd == pbu_pkg::CMD_WRITE) begin
            ram_we = wr_addr_ext < FrameBytes;
          end else if (32'(in_i.row) < DST_HEIGHT) begin
            quot_d  = prod[ProdW-1:DivShift];
            x_d     = '0;
            col_d   = '0;
            acc_d   = '0;
            pos_d   = '0;
            word_d  = '0;
            state_d = pbu_pkg::ST_BASE;
          end
        end
      end
      pbu_pkg::ST_BASE: begin
        base_d  = base_full[AW-1:0];
        bit_d   = src_row[2:0];
        state_d = pbu_pkg::ST_ISSUE;
      end
      pbu_pkg::ST_ISSUE: begin
        // Read one pixel per cycle; step the column by SRC/DST in fixed point.
        p1_vld_d = 1'b1;
        p1_ok_d  = x_ok;
        p1_pos_d = pos_q;
        x_d      = x_q + 1'b1;
        if (x_ok) begin
          acc_d = acc_wrap ? acc_sum - AccW'(DST_WIDTH) : acc_sum;
          col_d = col_q + CW'(ColInt) + CW'(acc_wrap);
        end
        pos_d = pos_q + 1'b1;
        if (pos_q == 4'hF) begin
          state_d = pbu_pkg::ST_FLUSH;
        end
      end
      pbu_pkg::ST_FLUSH: begin
        state_d = pbu_pkg::ST_PUSH;
      end
      pbu_pkg::ST_PUSH: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          pixels_d  = pack_word(lit_q);
          widx_d    = word_q;
          last_d    = (32'(word_q) == NumWords - 1);
          if (32'(word_q) == NumWords - 1) begin
            state_d = pbu_pkg::ST_IDLE;
          end else begin
            word_d  = word_q + 1'b1;
            pos_d   = '0;
            state_d = pbu_pkg::ST_ISSUE;
          end
        end
      end
      default: begin
        state_d = pbu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pbu_pkg::ST_CLEAR;
      clr_q     <= '0;
      p1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      p1_vld_q  <= p1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q   <= quot_d;
    base_q   <= base_d;
    bit_q    <= bit_d;
    x_q      <= x_d;
    col_q    <= col_d;
    acc_q    <= acc_d;
    pos_q    <= pos_d;
    word_q   <= word_d;
    p1_ok_q  <= p1_ok_d;
    p1_pos_q <= p1_pos_d;
    pixels_q <= pixels_d;
    widx_q   <= widx_d;
    last_q   <= last_d;
    // Capture the pixel whose RAM read was issued last cycle
    if (p1_vld_q) begin
      lit_q[p1_pos_q] <= p1_ok_q & ram_rdata[bit_q];
    end
  end

  pbu_ram #(
    .WIDTH (8),
    .DEPTH (FrameBytes)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: src/pbu_ram.sv
`timescale 1ns / 1ps

module pbu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
